### hdl/cfs_pkg.sv
package cfs_pkg;

  // Defaults for the top level parameters
  localparam int CFS_SAMPLE_WIDTH    = 16;
  localparam int CFS_PHASE_WIDTH     = 32;
  localparam int CFS_TABLE_ADDR_BITS = 10;

  // The increment register is always 32 bits; one turn is 2^32
  localparam int INC_WIDTH = 32;

  // 2*pi in Q3.30 and one in Q30, used to build the quarter-wave table
  localparam longint TWO_PI_Q30 = 64'sd6746518852;
  localparam longint Q30_ONE    = 64'sd1 <<< 30;

  // Quadrant codes, top two bits of the table index
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // One step of the Taylor recurrence: term * theta^2, truncated after each product
  function automatic longint taylor_step(longint term, longint theta);
    longint t;
    t = (term * theta) >>> 30;
    return (t * theta) >>> 30;
  endfunction

  function automatic longint series_sin(longint th);
    longint t;
    longint s;
    t = th;
    s = th;
    t = taylor_step(t, th) / 6;   s = s - t;
    t = taylor_step(t, th) / 20;  s = s + t;
    t = taylor_step(t, th) / 42;  s = s - t;
    t = taylor_step(t, th) / 72;  s = s + t;
    t = taylor_step(t, th) / 110; s = s - t;
    t = taylor_step(t, th) / 156; s = s + t;
    t = taylor_step(t, th) / 210; s = s - t;
    t = taylor_step(t, th) / 272; s = s + t;
    t = taylor_step(t, th) / 342; s = s - t;
    t = taylor_step(t, th) / 420; s = s + t;
    return s;
  endfunction

  function automatic longint series_cos(longint th);
    longint t;
    longint s;
    t = Q30_ONE;
    s = Q30_ONE;
    t = taylor_step(t, th) / 2;   s = s - t;
    t = taylor_step(t, th) / 12;  s = s + t;
    t = taylor_step(t, th) / 30;  s = s - t;
    t = taylor_step(t, th) / 56;  s = s + t;
    t = taylor_step(t, th) / 90;  s = s - t;
    t = taylor_step(t, th) / 132; s = s + t;
    t = taylor_step(t, th) / 182; s = s - t;
    t = taylor_step(t, th) / 240; s = s + t;
    t = taylor_step(t, th) / 306; s = s - t;
    t = taylor_step(t, th) / 380; s = s + t;
    return s;
  endfunction

  // Q30 value to sample amplitude, round half up, clamped to zero and full scale
  function automatic longint scale_q30(longint v, int sw);
    longint amp;
    longint x;
    longint r;
    amp = (64'sd1 <<< (sw - 1)) - 64'sd1;
    x = (v < 0) ? 64'sd0 : v;
    r = (x * amp + (64'sd1 <<< 29)) >>> 30;
    return (r > amp) ? amp : r;
  endfunction

  function automatic longint quarter_theta(longint r, int abits);
    return (TWO_PI_Q30 * r + (64'sd1 <<< (abits - 1))) >>> abits;
  endfunction

  function automatic longint quarter_sin(longint r, int abits, int sw);
    return scale_q30(series_sin(quarter_theta(r, abits)), sw);
  endfunction

  function automatic longint quarter_cos(longint r, int abits, int sw);
    return scale_q30(series_cos(quarter_theta(r, abits)), sw);
  endfunction

endpackage

### hdl/cfs_sample_if.sv
interface cfs_sample_if import cfs_pkg::*; #(
  parameter int SAMPLE_WIDTH = CFS_SAMPLE_WIDTH
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_re;
  logic signed [SAMPLE_WIDTH-1:0] sample_im;
  logic                           last_sample;

  modport source (output valid, sample_re, sample_im, last_sample, input ready);
  modport sink (input valid, sample_re, sample_im, last_sample, output ready);
endinterface

### hdl/cfs_result_if.sv
interface cfs_result_if import cfs_pkg::*; #(
  parameter int SAMPLE_WIDTH = CFS_SAMPLE_WIDTH
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] shifted_re;
  logic signed [SAMPLE_WIDTH-1:0] shifted_im;
  logic                           result_last;

  modport source (output valid, shifted_re, shifted_im, result_last, input ready);
  modport sink (input valid, shifted_re, shifted_im, result_last, output ready);
endinterface

### hdl/complex_frequency_shifter_top.sv
// Complex frequency shifter: rotates each sample by the phase of a running NCO.
// Registered stages from request accept to result valid: lookup, multiply, round.
// Throughput: one request per cycle while results are taken; the three stages advance independently,
// so a bubble is filled while a finished result waits at the output.
// Reset (rst, synchronous, active high) clears the phase accumulator, the
// phase increment and all stage valids; the sine table is constant logic.
module complex_frequency_shifter_top import cfs_pkg::*; #(
  parameter int SAMPLE_WIDTH    = CFS_SAMPLE_WIDTH,
  parameter int PHASE_WIDTH     = CFS_PHASE_WIDTH,
  parameter int TABLE_ADDR_BITS = CFS_TABLE_ADDR_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [INC_WIDTH-1:0] cfg_data,
  cfs_sample_if.sink           samples,
  cfs_result_if.source         results
);

  localparam int QUARTER_BITS = TABLE_ADDR_BITS - 2;
  localparam int QUARTER      = 1 << QUARTER_BITS;
  localparam int PROD_W       = 2 * SAMPLE_WIDTH;
  localparam int SUM_W        = PROD_W + 1;
  // width left after dropping SAMPLE_WIDTH-1 fraction bits
  localparam int RES_W        = SUM_W - (SAMPLE_WIDTH - 1);

  localparam logic signed [SUM_W-1:0] HALF    = SUM_W'(64'sd1 <<< (SAMPLE_WIDTH - 2));
  localparam logic signed [RES_W-1:0] SAT_MAX =
    RES_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [RES_W-1:0] SAT_MIN = -SAT_MAX - RES_W'(1);

  // ---------------------------------------------------------------------------
  // Configuration and phase accumulator
  // ---------------------------------------------------------------------------
  logic [INC_WIDTH-1:0]   phase_increment;
  logic [PHASE_WIDTH-1:0] phase_acc;
  logic [PHASE_WIDTH-1:0] inc_aligned;
  logic                   accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_increment <= '0;
    end else if (cfg_we) begin
      phase_increment <= cfg_data;
    end
  end

  // Increment is a fraction of a turn aligned to the top of the accumulator
  generate
    if (PHASE_WIDTH >= INC_WIDTH) begin : g_inc_wide
      assign inc_aligned =
        PHASE_WIDTH'({phase_increment, {(PHASE_WIDTH - INC_WIDTH + 1){1'b0}}} >> 1);
    end else begin : g_inc_narrow
      assign inc_aligned = phase_increment[INC_WIDTH-1 -: PHASE_WIDTH];
    end
  endgenerate

  // Current sample uses the current phase; a last sample restarts at zero
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
    end else if (accept) begin
      phase_acc <= samples.last_sample ? '0 : phase_acc + inc_aligned;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage enables: each stage loads when it is empty or its successor loads
  // ---------------------------------------------------------------------------
  logic v1, v2, v3;
  logic en1, en2, en3;

  assign en3 = !v3 || results.ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign samples.ready = en1;
  assign accept        = samples.valid && en1;

  // ---------------------------------------------------------------------------
  // Quarter-wave sine/cosine table, built at elaboration
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_WIDTH-1:0] sin_rom [QUARTER];
  logic signed [SAMPLE_WIDTH-1:0] cos_rom [QUARTER];

  generate
    for (genvar i = 0; i < QUARTER; i++) begin : g_rom
      assign sin_rom[i] =
        SAMPLE_WIDTH'(quarter_sin(longint'(i), TABLE_ADDR_BITS, SAMPLE_WIDTH));
      assign cos_rom[i] =
        SAMPLE_WIDTH'(quarter_cos(longint'(i), TABLE_ADDR_BITS, SAMPLE_WIDTH));
    end
  endgenerate

  logic [TABLE_ADDR_BITS-1:0]     tab_idx;
  logic [1:0]                     quad;
  logic [QUARTER_BITS-1:0]        qaddr;
  logic signed [SAMPLE_WIDTH-1:0] s_raw, c_raw;
  logic signed [SAMPLE_WIDTH-1:0] sn_next, cs_next;

  assign tab_idx = phase_acc[PHASE_WIDTH-1 -: TABLE_ADDR_BITS];
  assign quad    = tab_idx[TABLE_ADDR_BITS-1 -: 2];
  assign qaddr   = tab_idx[QUARTER_BITS-1:0];
  assign s_raw   = sin_rom[qaddr];
  assign c_raw   = cos_rom[qaddr];

  // Fold the quarter wave out to the full turn
  always_comb begin
    case (quad)
      QUAD_0: begin
        sn_next = s_raw;
        cs_next = c_raw;
      end
      QUAD_1: begin
        sn_next = c_raw;
        cs_next = -s_raw;
      end
      QUAD_2: begin
        sn_next = -s_raw;
        cs_next = -c_raw;
      end
      default: begin
        sn_next = -c_raw;
        cs_next = s_raw;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stage 1: sample and rotation coefficients
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_WIDTH-1:0] x1, y1, sn1, cs1;
  logic                           last1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x1    <= samples.sample_re;
      y1    <= samples.sample_im;
      last1 <= samples.last_sample;
      sn1   <= sn_next;
      cs1   <= cs_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: four partial products
  // ---------------------------------------------------------------------------
  logic signed [PROD_W-1:0] p_xc, p_ys, p_xs, p_yc;
  logic                     last2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      p_xc  <= x1 * cs1;
      p_ys  <= y1 * sn1;
      p_xs  <= x1 * sn1;
      p_yc  <= y1 * cs1;
      last2 <= last1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: combine, round half up, saturate
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0]        sum_re, sum_im, shr_re, shr_im;
  logic signed [RES_W-1:0]        r_re, r_im;
  logic signed [SAMPLE_WIDTH-1:0] re_next, im_next;

  assign sum_re = SUM_W'(p_xc) - SUM_W'(p_ys) + HALF;
  assign sum_im = SUM_W'(p_xs) + SUM_W'(p_yc) + HALF;
  assign shr_re = sum_re >>> (SAMPLE_WIDTH - 1);
  assign shr_im = sum_im >>> (SAMPLE_WIDTH - 1);
  assign r_re   = shr_re[RES_W-1:0];
  assign r_im   = shr_im[RES_W-1:0];

  always_comb begin
    if (r_re > SAT_MAX) begin
      re_next = SAT_MAX[SAMPLE_WIDTH-1:0];
    end else if (r_re < SAT_MIN) begin
      re_next = SAT_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      re_next = r_re[SAMPLE_WIDTH-1:0];
    end
    if (r_im > SAT_MAX) begin
      im_next = SAT_MAX[SAMPLE_WIDTH-1:0];
    end else if (r_im < SAT_MIN) begin
      im_next = SAT_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      im_next = r_im[SAMPLE_WIDTH-1:0];
    end
  end

  logic signed [SAMPLE_WIDTH-1:0] out_re, out_im;
  logic                           out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      out_re   <= re_next;
      out_im   <= im_next;
      out_last <= last2;
    end
  end

  assign results.valid       = v3;
  assign results.shifted_re  = out_re;
  assign results.shifted_im  = out_im;
  assign results.result_last = out_last;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // A last sample always restarts the phase at zero
  a_last_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && samples.last_sample) |=> (phase_acc == '0))
    else $error("phase not cleared after last sample");

  // Any other sample advances the phase by exactly one increment
  a_phase_step: assert property (@(posedge clk) disable iff (rst)
    (accept && !samples.last_sample) |=> (phase_acc == $past(phase_acc + inc_aligned)))
    else $error("phase step mismatch");

  // Input only stalls when the output holds a result nobody takes
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !samples.ready |-> (results.valid && !results.ready && v1 && v2))
    else $error("input stalled with room in the pipeline");

  // No result leaves right after reset
  a_reset_empty: assert property (@(posedge clk)
    $fell(rst) |-> !results.valid)
    else $error("result valid right after reset");

endmodule
